>>> rtl/rci_pkg.sv
// widths, codes and latency helpers for the ray / cone intersection pipeline
// no dependencies; used by every module of the block but rci_dly
package rci_pkg;

	// field and register widths
	localparam int CRD_W   = 32;
	localparam int SLOPE_W = 31;
	localparam int DIST_W  = 32;

	// internal datapath widths
	localparam int EXT_W     = CRD_W + 1;          // origin minus apex
	localparam int S2_W      = 2 * SLOPE_W;        // slope squared
	localparam int P1_W      = 2 * EXT_W;          // first-level products
	localparam int SUM_W     = P1_W + 1;           // sum of two products
	localparam int P2_W      = P1_W + S2_W + 1;    // product with slope squared
	localparam int COEF_W    = 130;                // quadratic coefficients
	localparam int PROD_W    = 2 * COEF_W;         // coefficient products
	localparam int DISC_W    = PROD_W + 1;         // discriminant
	localparam int SQ_IN_W   = 256;                // square root operand
	localparam int ROOT_W    = SQ_IN_W / 2;        // square root result
	localparam int SQ_REM_W  = ROOT_W + 2;         // square root remainder
	localparam int G_W       = COEF_W + 1;         // signed half linear term
	localparam int NUM_W     = G_W + 1;            // root numerators
	localparam int DIV_W     = COEF_W + DIST_W;    // divider remainder
	localparam int SHIFT_HI  = 32;                 // scale step of the coefficients
	localparam int FRAC_W    = 16;                 // fraction bits of the result

	localparam logic [SLOPE_W-1:0] SLOPE_RESET = SLOPE_W'(65536);

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_APEX_X     = 2'd0,
		REG_APEX_Y     = 2'd1,
		REG_APEX_Z     = 2'd2,
		REG_CONE_SLOPE = 2'd3
	} cfg_reg_t;

	// item data carried alongside the square root
	typedef struct packed {
		logic                     miss;
		logic                     neg;      // leading coefficient below zero
		logic signed [G_W-1:0]    g;
		logic [COEF_W-1:0]        den;
	} sq_side_t;

	// item flags carried alongside the divider
	typedef struct packed {
		logic hit;
		logic sat;
	} dv_side_t;

	// latency of the limb-serial multiplier
	function automatic int mul_lat(input int wa, input int wb);
		return ((wa + 31) / 32) * ((wb + 31) / 32) + 3;
	endfunction

	localparam int LAT_MUL1 = mul_lat(EXT_W, EXT_W);
	localparam int LAT_MUL2 = mul_lat(P1_W, S2_W + 1);
	localparam int LAT_COEF = LAT_MUL1 + LAT_MUL2 + 1;
	localparam int LAT_DISC = mul_lat(COEF_W, COEF_W);
	localparam int LAT_SQRT = ROOT_W;
	localparam int LAT_DIV  = DIST_W;

endpackage

>>> rtl/rci_dly.sv
// delay line of pipeline registers with a shared advance enable
// no dependencies
module rci_dly #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_s [0:D-1];

	// shift on every advance
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s[0] <= d;
			for (int i = 1; i < D; i++) begin
				sr_s[i] <= sr_s[i-1];
			end
		end
	end

	assign q = sr_s[D-1];

endmodule

>>> rtl/rci_mul.sv
// pipelined signed multiplier, one 32x32 limb product per stage
// depends on rci_pkg for the default widths
module rci_mul #(
	parameter int WA = rci_pkg::COEF_W,
	parameter int WB = rci_pkg::COEF_W
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);

	localparam int LA = (WA + 31) / 32;
	localparam int LB = (WB + 31) / 32;
	localparam int NP = LA * LB;
	localparam int OW = 32 * (LA + LB);
	localparam int SHL = 32 * ((NP - 1) / LB + (NP - 1) % LB);

	logic [WA-1:0]      mag_a;
	logic [WB-1:0]      mag_b;
	logic [32*LA-1:0]   am_s  [0:NP-1];
	logic [32*LB-1:0]   bm_s  [0:NP-1];
	logic               ng_s  [0:NP+1];
	logic [63:0]        pp_s  [1:NP];
	logic [OW-1:0]      acc_s [1:NP+1];
	logic signed [WA+WB-1:0] p_s;

	// magnitudes and result sign
	assign mag_a = a[WA-1] ? WA'(-a) : WA'(a);
	assign mag_b = b[WB-1] ? WB'(-b) : WB'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			am_s[0] <= (32*LA)'(mag_a);
			bm_s[0] <= (32*LB)'(mag_b);
			ng_s[0] <= a[WA-1] ^ b[WB-1];
		end
	end

	// one limb product per stage, accumulated one stage later
	for (genvar k = 1; k <= NP; k++) begin : g_pp
		localparam int IA = (k - 1) / LB;
		localparam int IB = (k - 1) % LB;

		always_ff @(posedge clk) begin
			if (en) begin
				pp_s[k] <= am_s[k-1][32*IA +: 32] * bm_s[k-1][32*IB +: 32];
				ng_s[k] <= ng_s[k-1];
			end
		end

		if (k < NP) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					am_s[k] <= am_s[k-1];
					bm_s[k] <= bm_s[k-1];
				end
			end
		end

		if (k == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[1] <= '0;
				end
			end
		end else begin : g_acc
			localparam int SH = 32 * ((k - 2) / LB + (k - 2) % LB);
			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[k] <= acc_s[k-1] + (OW'(pp_s[k-1]) << SH);
				end
			end
		end
	end

	// last product and sign
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[NP+1] <= acc_s[NP] + (OW'(pp_s[NP]) << SHL);
			ng_s[NP+1]  <= ng_s[NP];
			p_s         <= ng_s[NP+1] ? -(WA+WB)'(acc_s[NP+1]) : (WA+WB)'(acc_s[NP+1]);
		end
	end

	assign p = p_s;

endmodule

>>> rtl/rci_coef.sv
// one quadratic coefficient: 2^32*(p1*q1 + p2*q2) - s2*p3*q3
// depends on rci_pkg, rci_mul and rci_dly
module rci_coef (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [rci_pkg::EXT_W-1:0]   p1,
	input  logic signed [rci_pkg::EXT_W-1:0]   q1,
	input  logic signed [rci_pkg::EXT_W-1:0]   p2,
	input  logic signed [rci_pkg::EXT_W-1:0]   q2,
	input  logic signed [rci_pkg::EXT_W-1:0]   p3,
	input  logic signed [rci_pkg::EXT_W-1:0]   q3,
	input  logic [rci_pkg::S2_W-1:0]           s2,
	output logic signed [rci_pkg::COEF_W-1:0]  coef
);
	import rci_pkg::*;

	logic signed [P1_W-1:0]   m1, m2, m3;
	logic [S2_W-1:0]          s2_d;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_d;
	logic signed [P2_W-1:0]   m4;
	logic signed [COEF_W-1:0] coef_s;

	// first-level products
	rci_mul #(.WA(EXT_W), .WB(EXT_W)) u_m1 (.clk(clk), .en(en), .a(p1), .b(q1), .p(m1));
	rci_mul #(.WA(EXT_W), .WB(EXT_W)) u_m2 (.clk(clk), .en(en), .a(p2), .b(q2), .p(m2));
	rci_mul #(.WA(EXT_W), .WB(EXT_W)) u_m3 (.clk(clk), .en(en), .a(p3), .b(q3), .p(m3));

	rci_dly #(.W(S2_W), .D(LAT_MUL1)) u_s2d (.clk(clk), .en(en), .d(s2), .q(s2_d));

	// sum of the plain terms waits for the slope product
	assign sum = SUM_W'(m1) + SUM_W'(m2);

	rci_dly #(.W(SUM_W), .D(LAT_MUL2)) u_sumd (.clk(clk), .en(en), .d(sum), .q(sum_d));

	rci_mul #(.WA(P1_W), .WB(S2_W + 1)) u_m4 (
		.clk(clk), .en(en), .a(m3), .b($signed({1'b0, s2_d})), .p(m4)
	);

	// scaled difference
	always_ff @(posedge clk) begin
		if (en) begin
			coef_s <= (COEF_W'(sum_d) <<< SHIFT_HI) - COEF_W'(m4);
		end
	end

	assign coef = coef_s;

endmodule

>>> rtl/rci_sqrt.sv
// pipelined floor square root, one result bit per stage
// depends on rci_pkg
module rci_sqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rci_pkg::SQ_IN_W-1:0]   x,
	output logic [rci_pkg::ROOT_W-1:0]    root
);
	import rci_pkg::*;

	logic [SQ_REM_W-1:0] rem_s  [1:ROOT_W-1];
	logic [ROOT_W-1:0]   root_s [1:ROOT_W];
	logic [SQ_IN_W-1:0]  xs_s   [1:ROOT_W-1];

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
		logic [SQ_REM_W-1:0]   rem_in;
		logic [ROOT_W-1:0]     root_in;
		logic [SQ_IN_W-1:0]    xs_in;
		logic [SQ_REM_W+1:0]   remx;
		logic [SQ_REM_W+1:0]   trial;
		logic                  ge;

		if (k == 1) begin : g_in
			assign rem_in  = '0;
			assign root_in = '0;
			assign xs_in   = x;
		end else begin : g_prev
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign xs_in   = xs_s[k-1];
		end

		// bring down two operand bits and try the next root bit
		assign remx  = {rem_in, xs_in[SQ_IN_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = remx >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
			end
		end

		if (k < ROOT_W) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? SQ_REM_W'(remx - trial) : SQ_REM_W'(remx);
					xs_s[k]  <= xs_in << 2;
				end
			end
		end
	end

	assign root = root_s[ROOT_W];

endmodule

>>> rtl/rci_div.sv
// pipelined restoring divider, one quotient bit per stage, msb first
// depends on rci_pkg
module rci_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rci_pkg::DIV_W-1:0]    num,
	input  logic [rci_pkg::COEF_W-1:0]   den,
	output logic [rci_pkg::DIST_W-1:0]   quo
);
	import rci_pkg::*;

	logic [DIV_W-1:0]  rem_s [1:DIST_W-1];
	logic [COEF_W-1:0] den_s [1:DIST_W-1];
	logic [DIST_W-1:0] q_s   [1:DIST_W];

	for (genvar k = 1; k <= DIST_W; k++) begin : g_stage
		localparam int B = DIST_W - k;
		logic [DIV_W-1:0]  rem_in;
		logic [COEF_W-1:0] den_in;
		logic [DIST_W-1:0] q_in;
		logic [DIV_W-1:0]  cmp;
		logic              ge;

		if (k == 1) begin : g_in
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_prev
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
		end

		// compare against the shifted divisor
		assign cmp = DIV_W'(den_in) << B;
		assign ge  = rem_in >= cmp;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k] <= {q_in[DIST_W-2:0], ge};
			end
		end

		if (k < DIST_W) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? rem_in - cmp : rem_in;
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign quo = q_s[DIST_W];

endmodule

>>> rtl/ray_cone_intersect_top.sv
// ray / cone intersection; throughput one item per cycle while no result is held
// the pipeline length is set by the 128-stage square root, the 32-stage divider
// and the limb-serial 130x130 multipliers
// a stalled result freezes the whole pipeline, bubbles are not squeezed out
// reset clears the valid bits and returns the cone registers to apex 0, slope 1.0
module ray_cone_intersect_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [rci_pkg::CRD_W-1:0]         cfg_data,
	input  logic                              ray_valid,
	output logic                              ray_stall,
	input  logic signed [rci_pkg::CRD_W-1:0]  origin_x,
	input  logic signed [rci_pkg::CRD_W-1:0]  origin_y,
	input  logic signed [rci_pkg::CRD_W-1:0]  origin_z,
	input  logic signed [rci_pkg::CRD_W-1:0]  dir_x,
	input  logic signed [rci_pkg::CRD_W-1:0]  dir_y,
	input  logic signed [rci_pkg::CRD_W-1:0]  dir_z,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              hit,
	output logic [rci_pkg::DIST_W-1:0]        hit_distance
);
	import rci_pkg::*;

	localparam int LT = 1 + LAT_COEF + LAT_DISC + 1 + LAT_SQRT + 1 + 1 + LAT_DIV + 1;

	logic                      en;
	logic [LT-1:0]             vld_q;
	logic signed [CRD_W-1:0]   apex_x_q, apex_y_q, apex_z_q;
	logic [SLOPE_W-1:0]        cone_slope_q;

	logic signed [EXT_W-1:0]   ex_s1, ey_s1, ez_s1, dx_s1, dy_s1, dz_s1;
	logic [S2_W-1:0]           s2_s1;

	logic signed [COEF_W-1:0]  a_c, h_c, c_c;
	logic signed [PROD_W-1:0]  hh, ac;
	logic signed [COEF_W-1:0]  a_d, h_d;

	logic signed [DISC_W-1:0]  disc_s2;
	logic                      zero_a_s2;
	logic                      aneg_s2;
	logic signed [G_W-1:0]     g_s2;
	logic [COEF_W-1:0]         den_s2;

	logic [ROOT_W-1:0]         root;
	logic signed [NUM_W-1:0]   root_x;
	sq_side_t                  sq_in, sq_out;

	logic signed [NUM_W-1:0]   n1_s3, n2_s3;
	logic                      miss_s3;
	logic [COEF_W-1:0]         den_s3;

	logic                      hit_s4;
	logic [DIV_W-1:0]          num_s4;
	logic [COEF_W-1:0]         den_s4;
	logic signed [NUM_W-1:0]   pick;

	logic [DIST_W-1:0]         quo;
	dv_side_t                  dv_in, dv_out;

	logic                      hit_s5;
	logic [DIST_W-1:0]         dist_s5;

	// whole pipeline advances unless a finished result is held
	assign en        = !(vld_q[LT-1] && res_stall);
	assign ray_stall = !en;
	assign res_valid = vld_q[LT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LT-2:0], ray_valid};
		end
	end

	// cone registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apex_x_q     <= '0;
			apex_y_q     <= '0;
			apex_z_q     <= '0;
			cone_slope_q <= SLOPE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_APEX_X:     apex_x_q     <= $signed(cfg_data);
				REG_APEX_Y:     apex_y_q     <= $signed(cfg_data);
				REG_APEX_Z:     apex_z_q     <= $signed(cfg_data);
				REG_CONE_SLOPE: cone_slope_q <= cfg_data[SLOPE_W-1:0];
				default:        cone_slope_q <= cone_slope_q;
			endcase
		end
	end

	// stage 1: origin relative to apex, slope squared
	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1 <= EXT_W'(origin_x) - EXT_W'(apex_x_q);
			ey_s1 <= EXT_W'(origin_y) - EXT_W'(apex_y_q);
			ez_s1 <= EXT_W'(origin_z) - EXT_W'(apex_z_q);
			dx_s1 <= EXT_W'(dir_x);
			dy_s1 <= EXT_W'(dir_y);
			dz_s1 <= EXT_W'(dir_z);
			s2_s1 <= cone_slope_q * cone_slope_q;
		end
	end

	// quadratic coefficients
	rci_coef u_coef_a (
		.clk(clk), .en(en), .p1(dx_s1), .q1(dx_s1), .p2(dy_s1), .q2(dy_s1),
		.p3(dz_s1), .q3(dz_s1), .s2(s2_s1), .coef(a_c)
	);
	rci_coef u_coef_h (
		.clk(clk), .en(en), .p1(ex_s1), .q1(dx_s1), .p2(ey_s1), .q2(dy_s1),
		.p3(ez_s1), .q3(dz_s1), .s2(s2_s1), .coef(h_c)
	);
	rci_coef u_coef_c (
		.clk(clk), .en(en), .p1(ex_s1), .q1(ex_s1), .p2(ey_s1), .q2(ey_s1),
		.p3(ez_s1), .q3(ez_s1), .s2(s2_s1), .coef(c_c)
	);

	// discriminant products
	rci_mul #(.WA(COEF_W), .WB(COEF_W)) u_hh (.clk(clk), .en(en), .a(h_c), .b(h_c), .p(hh));
	rci_mul #(.WA(COEF_W), .WB(COEF_W)) u_ac (.clk(clk), .en(en), .a(a_c), .b(c_c), .p(ac));

	rci_dly #(.W(COEF_W), .D(LAT_DISC)) u_ad (.clk(clk), .en(en), .d(a_c), .q(a_d));
	rci_dly #(.W(COEF_W), .D(LAT_DISC)) u_hd (.clk(clk), .en(en), .d(h_c), .q(h_d));

	// stage 2: discriminant, sign-folded linear term, divisor magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			disc_s2   <= DISC_W'(hh) - DISC_W'(ac);
			zero_a_s2 <= a_d == '0;
			aneg_s2   <= a_d[COEF_W-1];
			g_s2      <= a_d[COEF_W-1] ? G_W'(h_d) : -G_W'(h_d);
			den_s2    <= a_d[COEF_W-1] ? COEF_W'(-a_d) : COEF_W'(a_d);
		end
	end

	rci_sqrt u_sqrt (.clk(clk), .en(en), .x(disc_s2[SQ_IN_W-1:0]), .root(root));

	assign sq_in.miss = zero_a_s2 | disc_s2[DISC_W-1];
	assign sq_in.neg  = aneg_s2;
	assign sq_in.g    = g_s2;
	assign sq_in.den  = den_s2;

	rci_dly #(.W($bits(sq_side_t)), .D(LAT_SQRT)) u_sqd (
		.clk(clk), .en(en), .d(sq_in), .q(sq_out)
	);

	assign root_x = NUM_W'($signed({1'b0, root}));

	// stage 3: both root numerators; a negative leading coefficient swaps the
	// sign of the root term in each
	always_ff @(posedge clk) begin
		if (en) begin
			n1_s3   <= sq_out.neg ? NUM_W'(sq_out.g) - root_x : NUM_W'(sq_out.g) + root_x;
			n2_s3   <= sq_out.neg ? NUM_W'(sq_out.g) + root_x : NUM_W'(sq_out.g) - root_x;
			miss_s3 <= sq_out.miss;
			den_s3  <= sq_out.den;
		end
	end

	// stage 4: root in front of the origin, n2 first; nearest when the leading coefficient is positive
	assign pick = !n2_s3[NUM_W-1] ? n2_s3 : n1_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= !miss_s3 && (!n2_s3[NUM_W-1] || !n1_s3[NUM_W-1]);
			num_s4 <= DIV_W'({pick[NUM_W-2:0], FRAC_W'(0)});
			den_s4 <= den_s3;
		end
	end

	rci_div u_div (.clk(clk), .en(en), .num(num_s4), .den(den_s4), .quo(quo));

	assign dv_in.hit = hit_s4;
	assign dv_in.sat = num_s4 >= {den_s4, DIST_W'(0)};

	rci_dly #(.W($bits(dv_side_t)), .D(LAT_DIV)) u_dvd (
		.clk(clk), .en(en), .d(dv_in), .q(dv_out)
	);

	// stage 5: result register
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5  <= dv_out.hit;
			dist_s5 <= !dv_out.hit ? '0 : (dv_out.sat ? '1 : quo);
		end
	end

	assign hit          = hit_s5;
	assign hit_distance = dist_s5;

endmodule
